// ===== rtl/core/svbrc_pkg.sv =====
// Shared types and constants for the servo bus response checker.
package svbrc_pkg;

   // Width of the idle tick counter; one bit wider than the timeout register.
   localparam int IdleWidth = 17;

   // Header byte value and the broadcast ID.
   localparam logic [7:0] HeaderByte  = 8'hFF;
   localparam logic [7:0] BroadcastId = 8'd254;
   localparam logic [7:0] NoTimeoutLength = 8'd255;
   localparam logic [7:0] ChecksumGood = 8'hFF;
   localparam logic [7:0] LengthOverhead = 8'd4;
   localparam logic [7:0] MinCheckedLength = 8'd3;
   localparam logic [15:0] TimeoutReset = 16'd1000;

   // Operation codes carried on the request channel.
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   // Status codes reported on the response channel.
   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_TIMEOUT      = 3'd1,
      ST_BAD_HEADER   = 3'd2,
      ST_ID_MISMATCH  = 3'd3,
      ST_BAD_LENGTH   = 3'd4,
      ST_BAD_CHECKSUM = 3'd5
   } status_type;

   // Snapshot of a packet at the moment it ends.
   typedef struct packed {
      logic       done;
      logic       timed_out;
      logic [7:0] byte_count;
      logic [7:0] target_count;
      logic [7:0] target_id;
      logic [7:0] running_sum;
      logic       header_good;
      logic [7:0] id_echo;
      logic [7:0] length_field;
   } finish_type;

   // One response item.
   typedef struct packed {
      status_type status;
      logic [7:0] received_length;
   } result_type;

endpackage

// ===== rtl/core/svbrc_tracker.sv =====
// Packet receive state: byte collection, idle tick counting and end detection.
module svbrc_tracker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [1:0]               operation,
   input  logic [7:0]               data_byte,
   input  logic [7:0]               expected_length,
   input  logic [7:0]               expected_id,
   input  logic                     csr_write,
   input  logic [15:0]              csr_data,
   output svbrc_pkg::finish_type    finish
);

   logic [15:0] timeout_ticks_ff, timeout_ticks_in;
   logic        busy_ff, busy_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  target_count_ff, target_count_in;
   logic [7:0]  target_id_ff, target_id_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic        header_good_ff, header_good_in;
   logic [7:0]  id_echo_ff, id_echo_in;
   logic [7:0]  length_field_ff, length_field_in;
   logic [svbrc_pkg::IdleWidth-1:0] idle_ticks_ff, idle_ticks_in;
   logic [svbrc_pkg::IdleWidth-1:0] idle_limit;
   logic        done;
   logic        timed_out;

   // Configuration register write.
   assign timeout_ticks_in = csr_write ? csr_data : timeout_ticks_ff;

   // Timeout fires when the idle count exceeds the register value plus one.
   assign idle_limit = {1'b0, timeout_ticks_ff} + svbrc_pkg::IdleWidth'(1);

   // Next state for one accepted transaction.
   always_comb begin
      busy_in         = busy_ff;
      byte_count_in   = byte_count_ff;
      target_count_in = target_count_ff;
      target_id_in    = target_id_ff;
      running_sum_in  = running_sum_ff;
      header_good_in  = header_good_ff;
      id_echo_in      = id_echo_ff;
      length_field_in = length_field_ff;
      idle_ticks_in   = idle_ticks_ff;
      done            = 1'b0;
      timed_out       = 1'b0;
      if (accept) begin
         case (svbrc_pkg::op_type'(operation))
            svbrc_pkg::OP_START: begin
               busy_in         = 1'b1;
               byte_count_in   = '0;
               target_count_in = expected_length;
               target_id_in    = expected_id;
               running_sum_in  = '0;
               header_good_in  = 1'b1;
               id_echo_in      = '0;
               length_field_in = '0;
               idle_ticks_in   = '0;
               // A zero length packet ends with its own start.
               if (expected_length == 8'd0) begin
                  busy_in = 1'b0;
                  done    = 1'b1;
               end
            end
            svbrc_pkg::OP_BYTE: begin
               if (busy_ff) begin
                  if (byte_count_ff < 8'd2) begin
                     if (data_byte != svbrc_pkg::HeaderByte) begin
                        header_good_in = 1'b0;
                     end
                  end else begin
                     running_sum_in = running_sum_ff + data_byte;
                     if (byte_count_ff == 8'd2) begin
                        id_echo_in = data_byte;
                     end else if (byte_count_ff == 8'd3) begin
                        length_field_in = data_byte;
                     end
                  end
                  byte_count_in = byte_count_ff + 8'd1;
                  idle_ticks_in = '0;
                  if (byte_count_in == target_count_ff) begin
                     busy_in = 1'b0;
                     done    = 1'b1;
                  end
               end
            end
            svbrc_pkg::OP_TICK: begin
               if (busy_ff) begin
                  idle_ticks_in = idle_ticks_ff + svbrc_pkg::IdleWidth'(1);
                  if (idle_ticks_in > idle_limit) begin
                     busy_in   = 1'b0;
                     done      = 1'b1;
                     timed_out = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= svbrc_pkg::TimeoutReset;
         busy_ff          <= 1'b0;
         byte_count_ff    <= '0;
         target_count_ff  <= '0;
         target_id_ff     <= '0;
         running_sum_ff   <= '0;
         header_good_ff   <= 1'b1;
         id_echo_ff       <= '0;
         length_field_ff  <= '0;
         idle_ticks_ff    <= '0;
      end else begin
         timeout_ticks_ff <= timeout_ticks_in;
         busy_ff          <= busy_in;
         byte_count_ff    <= byte_count_in;
         target_count_ff  <= target_count_in;
         target_id_ff     <= target_id_in;
         running_sum_ff   <= running_sum_in;
         header_good_ff   <= header_good_in;
         id_echo_ff       <= id_echo_in;
         length_field_ff  <= length_field_in;
         idle_ticks_ff    <= idle_ticks_in;
      end
   end

   // Packet view after this transaction, for the status check.
   always_comb begin
      finish.done         = done;
      finish.timed_out    = timed_out;
      finish.byte_count   = byte_count_in;
      finish.target_count = target_count_in;
      finish.target_id    = target_id_in;
      finish.running_sum  = running_sum_in;
      finish.header_good  = header_good_in;
      finish.id_echo      = id_echo_in;
      finish.length_field = length_field_in;
   end

endmodule

// ===== rtl/core/svbrc_status.sv =====
// Status evaluation of a finished packet.
module svbrc_status (
   input  svbrc_pkg::finish_type finish,
   output svbrc_pkg::result_type result
);

   svbrc_pkg::status_type status;

   // Checks in priority order; broadcast packets are never checked.
   always_comb begin
      status = svbrc_pkg::ST_OK;
      if (finish.target_id != svbrc_pkg::BroadcastId) begin
         if (finish.timed_out && finish.target_count != svbrc_pkg::NoTimeoutLength) begin
            status = svbrc_pkg::ST_TIMEOUT;
         end else if (finish.byte_count > svbrc_pkg::MinCheckedLength) begin
            if (!finish.header_good) begin
               status = svbrc_pkg::ST_BAD_HEADER;
            end else if (finish.id_echo != finish.target_id) begin
               status = svbrc_pkg::ST_ID_MISMATCH;
            end else if (finish.length_field !=
                         (finish.byte_count - svbrc_pkg::LengthOverhead)) begin
               status = svbrc_pkg::ST_BAD_LENGTH;
            end else if (finish.running_sum != svbrc_pkg::ChecksumGood) begin
               status = svbrc_pkg::ST_BAD_CHECKSUM;
            end
         end
      end
   end

   // An error reports a length of zero.
   assign result.status          = status;
   assign result.received_length = (status == svbrc_pkg::ST_OK) ? finish.byte_count : 8'd0;

endmodule

// ===== rtl/core/svbrc_out_reg.sv =====
// Response output register; decouples the request side from response stalls.
module svbrc_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  svbrc_pkg::result_type result,
   input  logic                  out_ready,
   output logic                  out_valid,
   output svbrc_pkg::result_type out_result,
   output logic                  in_ready
);

   logic                  valid_ff, valid_in;
   svbrc_pkg::result_type result_ff, result_in;

   // New work may enter when the register is empty or is being drained.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (in_ready) begin
         valid_in  = load;
         result_in = result;
      end
   end

   // Valid flag is control state; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== rtl/core/servo_bus_response_checker.sv =====
// Top level of the servo bus response checker.
//
//   Channel   Direction  Handshake               Contents
//   req_      in         req_tvalid/req_tready   operation, byte, length, ID
//   rsp_      out        rsp_tvalid/rsp_tready   received length, status
//   csr_      in         csr_valid/csr_ready     timeout_ticks
//
// One request transaction is accepted per cycle while req_tready is high.
// The packet state and the response, if any, are registered together at
// the accepting edge. A stalled response holds the request side only while
// the output register is full and not being taken. Reset is synchronous and
// restores the timeout to 1000 ticks with no packet open.
module servo_bus_response_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // data_byte[7:0], expected_length[15:8], expected_id[23:16]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // received_length[7:0], status[10:8], zero[15:11]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic                  accept;
   svbrc_pkg::finish_type finish;
   svbrc_pkg::result_type result;
   svbrc_pkg::result_type out_result;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;

   svbrc_tracker u_tracker (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .operation       (req_tuser),
      .data_byte       (req_tdata[7:0]),
      .expected_length (req_tdata[15:8]),
      .expected_id     (req_tdata[23:16]),
      .csr_write       (csr_valid && csr_ready),
      .csr_data        (csr_data),
      .finish          (finish)
   );

   svbrc_status u_status (
      .finish (finish),
      .result (result)
   );

   svbrc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (finish.done),
      .result     (result),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_result (out_result),
      .in_ready   (req_tready)
   );

   assign rsp_tdata = {5'd0, out_result.status, out_result.received_length};

   // An error response always reports zero length.
   a_error_zero_length: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:8] != svbrc_pkg::ST_OK) |-> rsp_tdata[7:0] == 8'd0)
      else $error("error response with nonzero length");

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:8] <= svbrc_pkg::ST_BAD_CHECKSUM)
      else $error("undefined status code");

   // An empty output register never holds back requests.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output register");

   // A response appears only after a request transaction.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(accept))
      else $error("response without request transaction");

endmodule
